// ===== rtl/core/urm_pkg.sv =====
package urm_pkg;

  // counter width of the phase timer
  localparam int COUNTER_BITS = 17;
  // width used when the counter is compared against the 16-bit timeout
  localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  // distance arithmetic: distance = floor(ticks * 343 / 20000)
  localparam int DIST_BITS = 11;
  localparam int REM_BITS = 15;
  localparam logic [REM_BITS-1:0] REM_STEP = REM_BITS'(343);
  localparam logic [REM_BITS-1:0] REM_DIV = REM_BITS'(20000);

  // status codes and fixed distances on timeouts
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_RISE = 2'd1;
  localparam logic [1:0] STATUS_NO_FALL = 2'd2;
  localparam logic [DIST_BITS-1:0] DIST_NO_RISE = DIST_BITS'(998);
  localparam logic [DIST_BITS-1:0] DIST_NO_FALL = DIST_BITS'(999);

  // register map
  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_PULSE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_NEAR = 2'd3;

  localparam logic [7:0] SETTLE_RST = 8'd2;
  localparam logic [7:0] PULSE_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST = 16'd30000;
  localparam logic [9:0] NEAR_RST = 10'd50;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_PULSE  = 3'd2,
    PH_WAIT   = 3'd3,
    PH_HIGH   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [7:0]  pulse_ticks;
    logic [15:0] timeout_ticks;
    logic [9:0]  near_threshold_cm;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic                 trigger_level;
    logic                 busy_res;
    logic                 done_res;
    logic [1:0]           status;
    logic [DIST_BITS-1:0] distance_cm;
    logic                 near;
  } out_t;

endpackage

// ===== rtl/core/ultrasonic_range_measurer.sv =====
// path: an accepted beat is held in the input register, moves to the result register
//   when the result slot frees up, and is offered from there until it is taken
// throughput: one beat per cycle unless the output stalls; the tick step is one pass
//   of logic between the input register and the result register
// reset: asynchronous active low; clears valids, phase (idle), counter, and
//   loads the register defaults
module ultrasonic_range_measurer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  urm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output urm_pkg::out_t                 out_data_o
);

  urm_pkg::cfg_t cfg;

  // configuration registers
  urm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // tick engine
  urm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a finished measurement leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done beat reports busy");

  // result fields are zero on ticks without a finished measurement
  a_not_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |->
      out_data_o.status == urm_pkg::STATUS_OK && out_data_o.distance_cm == '0 &&
      !out_data_o.near)
    else $error("result fields set without done");

  // near only on a good measurement
  a_near_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.near |->
      out_data_o.done_res && out_data_o.status == urm_pkg::STATUS_OK)
    else $error("near without a good measurement");

  // the trigger pulse is always followed by more of the measurement
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |->
      out_data_o.busy_res && !out_data_o.done_res)
    else $error("trigger high outside a measurement");

endmodule

// ===== rtl/core/urm_cfg.sv =====
module urm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output urm_pkg::cfg_t                 cfg_o
);

  urm_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        urm_pkg::REG_SETTLE:  cfg_d.settle_ticks      = pwdata[7:0];
        urm_pkg::REG_PULSE:   cfg_d.pulse_ticks       = pwdata[7:0];
        urm_pkg::REG_TIMEOUT: cfg_d.timeout_ticks     = pwdata[15:0];
        urm_pkg::REG_NEAR:    cfg_d.near_threshold_cm = pwdata[9:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks      <= urm_pkg::SETTLE_RST;
      cfg_q.pulse_ticks       <= urm_pkg::PULSE_RST;
      cfg_q.timeout_ticks     <= urm_pkg::TIMEOUT_RST;
      cfg_q.near_threshold_cm <= urm_pkg::NEAR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      urm_pkg::REG_SETTLE:  prdata = {24'd0, cfg_q.settle_ticks};
      urm_pkg::REG_PULSE:   prdata = {24'd0, cfg_q.pulse_ticks};
      urm_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
      urm_pkg::REG_NEAR:    prdata = {22'd0, cfg_q.near_threshold_cm};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/urm_core.sv =====
module urm_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  urm_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  urm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output urm_pkg::out_t out_data_o
);

  localparam int CB = urm_pkg::COUNTER_BITS;
  localparam int DB = urm_pkg::DIST_BITS;
  localparam int RB = urm_pkg::REM_BITS;

  // pipeline registers
  logic          in_vld_q;
  urm_pkg::in_t  in_q;
  logic          out_vld_q;
  urm_pkg::out_t out_q;
  logic          adv;

  // measurement state
  urm_pkg::phase_e phase_q, phase_d;
  logic [CB-1:0]   cnt_q, cnt_d;
  logic [DB-1:0]   dist_q, dist_d;
  logic [RB-1:0]   rem_q, rem_d;

  // step results
  urm_pkg::out_t   res;
  logic [CB-1:0]   cnt_inc;
  logic            cnt_sat;
  logic [RB-1:0]   rem_sum;
  logic            rem_wrap;
  logic [RB-1:0]   rem_inc;
  logic [DB-1:0]   dist_inc;
  logic [CB-1:0]   settle_ext;
  logic [CB-1:0]   pulse_ext;
  logic [urm_pkg::CMP_BITS-1:0] tmo_ext;
  logic [urm_pkg::CMP_BITS-1:0] cnt_q_ext;
  logic [urm_pkg::CMP_BITS-1:0] cnt_inc_ext;
  logic            tmo_cur;
  logic            tmo_inc;

  // a beat moves from input to result register when the result slot frees up
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  // saturating counter increment
  assign cnt_sat = (cnt_q == {CB{1'b1}});
  assign cnt_inc = cnt_sat ? cnt_q : cnt_q + CB'(1);

  // distance kept in step with the counter while the echo is high: quotient and remainder of cnt*343/20000
  assign rem_sum  = rem_q + urm_pkg::REM_STEP;
  assign rem_wrap = (rem_sum >= urm_pkg::REM_DIV);
  assign rem_inc  = cnt_sat ? rem_q : (rem_wrap ? rem_sum - urm_pkg::REM_DIV : rem_sum);
  assign dist_inc = (cnt_sat || !rem_wrap) ? dist_q : dist_q + DB'(1);

  // threshold compares
  assign settle_ext  = CB'(cfg_i.settle_ticks);
  assign pulse_ext   = CB'(cfg_i.pulse_ticks);
  assign tmo_ext     = urm_pkg::CMP_BITS'(cfg_i.timeout_ticks);
  assign cnt_q_ext   = urm_pkg::CMP_BITS'(cnt_q);
  assign cnt_inc_ext = urm_pkg::CMP_BITS'(cnt_inc);
  assign tmo_cur     = (cnt_q_ext > tmo_ext) || cnt_sat;
  assign tmo_inc     = (cnt_inc_ext > tmo_ext) || (cnt_inc == {CB{1'b1}});

  // next state and result of one tick
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dist_d  = dist_q;
    rem_d   = rem_q;
    res     = '0;
    case (phase_q)
      urm_pkg::PH_IDLE: begin
        if (in_q.start_req) begin
          if (settle_ext <= CB'(1)) begin
            phase_d = urm_pkg::PH_PULSE;
            cnt_d   = '0;
          end else begin
            phase_d = urm_pkg::PH_SETTLE;
            cnt_d   = CB'(1);
          end
        end
      end
      urm_pkg::PH_SETTLE: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= settle_ext) begin
          phase_d = urm_pkg::PH_PULSE;
          cnt_d   = '0;
        end
      end
      urm_pkg::PH_PULSE: begin
        res.trigger_level = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= pulse_ext) begin
          phase_d = urm_pkg::PH_WAIT;
          cnt_d   = '0;
        end
      end
      urm_pkg::PH_WAIT: begin
        if (in_q.echo_level) begin
          phase_d = urm_pkg::PH_HIGH;
          cnt_d   = '0;
          dist_d  = '0;
          rem_d   = '0;
        end else if (tmo_cur) begin
          res.done_res    = 1'b1;
          res.status      = urm_pkg::STATUS_NO_RISE;
          res.distance_cm = urm_pkg::DIST_NO_RISE;
          phase_d = urm_pkg::PH_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      urm_pkg::PH_HIGH: begin
        cnt_d  = cnt_inc;
        dist_d = dist_inc;
        rem_d  = rem_inc;
        if (!in_q.echo_level) begin
          res.done_res    = 1'b1;
          res.status      = urm_pkg::STATUS_OK;
          res.distance_cm = dist_inc;
          res.near        = (dist_inc < DB'(cfg_i.near_threshold_cm));
          phase_d = urm_pkg::PH_IDLE;
          cnt_d   = '0;
        end else if (tmo_inc) begin
          res.done_res    = 1'b1;
          res.status      = urm_pkg::STATUS_NO_FALL;
          res.distance_cm = urm_pkg::DIST_NO_FALL;
          phase_d = urm_pkg::PH_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        phase_d = urm_pkg::PH_IDLE;
        cnt_d   = '0;
      end
    endcase
    res.busy_res = (phase_d != urm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urm_pkg::PH_IDLE;
      cnt_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ===== sim/tb_ultrasonic_range_measurer.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_range_measurer;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int CB = urm_pkg::COUNTER_BITS;
  localparam int DB = urm_pkg::DIST_BITS;
  localparam int AB = urm_pkg::ADDR_BITS;
  localparam logic [CB-1:0] CNT_SAT = '1;

  // one row of the directed table
  typedef struct {
    bit            start_req;
    bit            echo_level;
    bit            fixed_exp;
    urm_pkg::out_t want;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AB-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i;
  logic          in_stall_o;
  urm_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  urm_pkg::out_t out_data_o;

  // typed expectation travelling with the current input beat
  bit            row_fixed = 1'b0;
  urm_pkg::out_t row_want = '0;

  // ranging predictor state and register shadow
  urm_pkg::phase_e sim_phase;
  logic [CB-1:0]   sim_ticks;
  urm_pkg::cfg_t   cfg_shadow;

  urm_pkg::out_t pending_readings[$];
  dir_row_t      dir_rows[$];
  int            beats_sent;
  int            mismatches;
  int            cycle_count;
  int            src_idle_pct;
  int            sink_stall_pct;

  ultrasonic_range_measurer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ultrasonic_range_measurer: errors");
      $finish;
    end
  end

  function automatic logic [CB-1:0] tick_up(logic [CB-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  function automatic bit wait_expired(logic [CB-1:0] c);
    return (c > cfg_shadow.timeout_ticks) || (c == CNT_SAT);
  endfunction

  // one microsecond tick of the ranging state machine
  function automatic urm_pkg::out_t range_tick(urm_pkg::in_t beat);
    urm_pkg::out_t   r;
    longint unsigned prod;
    r = '0;
    case (sim_phase)
      urm_pkg::PH_IDLE: begin
        if (beat.start_req) begin
          // the start tick already counts as the first settle tick
          if (cfg_shadow.settle_ticks <= 8'd1) begin
            sim_phase = urm_pkg::PH_PULSE;
            sim_ticks = '0;
          end else begin
            sim_phase = urm_pkg::PH_SETTLE;
            sim_ticks = CB'(1);
          end
        end
      end
      urm_pkg::PH_SETTLE: begin
        sim_ticks = tick_up(sim_ticks);
        if (sim_ticks >= cfg_shadow.settle_ticks) begin
          sim_phase = urm_pkg::PH_PULSE;
          sim_ticks = '0;
        end
      end
      urm_pkg::PH_PULSE: begin
        r.trigger_level = 1'b1;
        sim_ticks = tick_up(sim_ticks);
        if (sim_ticks >= cfg_shadow.pulse_ticks) begin
          sim_phase = urm_pkg::PH_WAIT;
          sim_ticks = '0;
        end
      end
      urm_pkg::PH_WAIT: begin
        if (beat.echo_level) begin
          sim_phase = urm_pkg::PH_HIGH;
          sim_ticks = '0;
        end else if (wait_expired(sim_ticks)) begin
          r.done_res    = 1'b1;
          r.status      = urm_pkg::STATUS_NO_RISE;
          r.distance_cm = urm_pkg::DIST_NO_RISE;
          sim_phase = urm_pkg::PH_IDLE;
          sim_ticks = '0;
        end else begin
          sim_ticks = tick_up(sim_ticks);
        end
      end
      urm_pkg::PH_HIGH: begin
        sim_ticks = tick_up(sim_ticks);
        if (!beat.echo_level) begin
          // exact floor of ticks * 0.01715 cm
          prod = (64'(sim_ticks) * 64'd343) / 64'd20000;
          r.done_res    = 1'b1;
          r.status      = urm_pkg::STATUS_OK;
          r.distance_cm = prod[DB-1:0];
          r.near        = (r.distance_cm < cfg_shadow.near_threshold_cm);
          sim_phase = urm_pkg::PH_IDLE;
          sim_ticks = '0;
        end else if (wait_expired(sim_ticks)) begin
          r.done_res    = 1'b1;
          r.status      = urm_pkg::STATUS_NO_FALL;
          r.distance_cm = urm_pkg::DIST_NO_FALL;
          sim_phase = urm_pkg::PH_IDLE;
          sim_ticks = '0;
        end
      end
      default: begin
        sim_phase = urm_pkg::PH_IDLE;
        sim_ticks = '0;
      end
    endcase
    r.busy_res = (sim_phase != urm_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic field_chk(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // predict on input beats, check output beats, random output stall
  always @(posedge clk_i) begin
    urm_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = range_tick(in_data_i);
        if (row_fixed) want = row_want;
        pending_readings.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none, got %p", $time, out_data_o);
        end else begin
          want = pending_readings.pop_front();
          field_chk("trigger_level", want.trigger_level, out_data_o.trigger_level);
          field_chk("busy_res", want.busy_res, out_data_o.busy_res);
          field_chk("done_res", want.done_res, out_data_o.done_res);
          field_chk("status", want.status, out_data_o.status);
          field_chk("distance_cm", want.distance_cm, out_data_o.distance_cm);
          field_chk("near", want.near, out_data_o.near);
        end
      end
    end
    out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);
  end

  // random source gap after a beat
  task automatic src_gap();
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
  endtask

  // present one tick beat and hold it until taken
  task automatic put_beat(bit st, bit ec, bit fixed = 1'b0, urm_pkg::out_t want = '0);
    in_valid_i <= 1'b1;
    in_data_i  <= '{start_req: st, echo_level: ec};
    row_fixed  <= fixed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    src_gap();
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  // apb write: setup then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AB'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      urm_pkg::REG_SETTLE:  cfg_shadow.settle_ticks = val[7:0];
      urm_pkg::REG_PULSE:   cfg_shadow.pulse_ticks = val[7:0];
      urm_pkg::REG_TIMEOUT: cfg_shadow.timeout_ticks = val[15:0];
      urm_pkg::REG_NEAR:    cfg_shadow.near_threshold_cm = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(urm_pkg::cfg_t c);
    reg_write(urm_pkg::REG_SETTLE, 32'(c.settle_ticks));
    reg_write(urm_pkg::REG_PULSE, 32'(c.pulse_ticks));
    reg_write(urm_pkg::REG_TIMEOUT, 32'(c.timeout_ticks));
    reg_write(urm_pkg::REG_NEAR, 32'(c.near_threshold_cm));
  endtask

  task automatic random_cfg();
    urm_pkg::cfg_t c;
    int            max_cm;
    c.settle_ticks = 8'($urandom_range(0, 6));
    c.pulse_ticks  = 8'($urandom_range(0, 6));
    c.timeout_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(40, 100))
                                                  : 16'($urandom_range(1, 16));
    max_cm = (int'(c.timeout_ticks) + 1) * 343 / 20000;
    case ($urandom_range(0, 3))
      0:       c.near_threshold_cm = '0;
      1:       c.near_threshold_cm = 10'd600;
      default: c.near_threshold_cm = 10'($urandom_range(0, max_cm + 1));
    endcase
    apply_cfg(c);
  endtask

  // well-formed measurement: start, trigger time, echo wait, echo high, echo low
  task automatic measure(int wait_len, int high_len);
    int lead;
    lead = ((cfg_shadow.settle_ticks == 0) ? 0 : int'(cfg_shadow.settle_ticks) - 1)
         + ((cfg_shadow.pulse_ticks == 0) ? 1 : int'(cfg_shadow.pulse_ticks));
    put_beat(1'b1, 1'b0);
    repeat (lead + wait_len) put_beat($urandom_range(0, 3) == 0, 1'b0);
    repeat (high_len) put_beat($urandom_range(0, 3) == 0, 1'b1);
    put_beat($urandom_range(0, 3) == 0, 1'b0);
  endtask

  // mostly measurements with random timing, some raw noise beats
  task automatic random_stretch(int budget);
    int stop_at;
    int t;
    int w;
    int h;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      t = int'(cfg_shadow.timeout_ticks);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 8)) put_beat($urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 3) == 0) w = $urandom_range(t, t + 2);
        else w = $urandom_range(0, (t < 6) ? t : 6);
        if ($urandom_range(0, 3) == 0) h = $urandom_range(t, t + 2);
        else h = $urandom_range(1, t + 1);
        measure(w, h);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_mode(int src_pct, int sink_pct, int budget);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (2) begin
      drain();
      random_cfg();
      random_stretch(budget / 2);
    end
  endtask

  function automatic urm_pkg::out_t done_word(logic [1:0] st, logic [DB-1:0] d);
    urm_pkg::out_t r;
    r = '0;
    r.done_res    = 1'b1;
    r.status      = st;
    r.distance_cm = d;
    return r;
  endfunction

  task automatic add_row(bit st, bit ec, bit fixed = 1'b0, urm_pkg::out_t want = '0);
    dir_row_t row;
    row.start_req  = st;
    row.echo_level = ec;
    row.fixed_exp  = fixed;
    row.want       = want;
    dir_rows.push_back(row);
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    sim_phase      = urm_pkg::PH_IDLE;
    sim_ticks      = '0;
    cfg_shadow     = '{urm_pkg::SETTLE_RST, urm_pkg::PULSE_RST, urm_pkg::TIMEOUT_RST,
                       urm_pkg::NEAR_RST};
    src_idle_pct   = 0;
    sink_stall_pct = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero settle, zero pulse, timeout register at 1, near threshold at 600
    apply_cfg('{settle_ticks: 8'd0, pulse_ticks: 8'd0, timeout_ticks: 16'd1,
                near_threshold_cm: 10'd600});
    add_row(1'b0, 1'b0, 1'b1, '0);
    add_row(1'b0, 1'b1, 1'b1, '0);
    // echo never rises, start while busy ignored
    add_row(1'b1, 1'b0);
    add_row(1'b0, 1'b0);
    add_row(1'b0, 1'b0);
    add_row(1'b1, 1'b0);
    add_row(1'b0, 1'b0, 1'b1, done_word(urm_pkg::STATUS_NO_RISE, urm_pkg::DIST_NO_RISE));
    // echo never falls
    add_row(1'b1, 1'b1);
    add_row(1'b1, 1'b1);
    add_row(1'b0, 1'b1);
    add_row(1'b0, 1'b1);
    add_row(1'b1, 1'b1, 1'b1, done_word(urm_pkg::STATUS_NO_FALL, urm_pkg::DIST_NO_FALL));
    // shortest echo, then one tick longer
    add_row(1'b1, 1'b0);
    add_row(1'b0, 1'b0);
    add_row(1'b0, 1'b1);
    add_row(1'b0, 1'b0);
    add_row(1'b1, 1'b0);
    add_row(1'b0, 1'b0);
    add_row(1'b0, 1'b1);
    add_row(1'b0, 1'b1);
    add_row(1'b0, 1'b0);
    add_row(1'b0, 1'b1, 1'b1, '0);
    foreach (dir_rows[i])
      put_beat(dir_rows[i].start_req, dir_rows[i].echo_level, dir_rows[i].fixed_exp,
               dir_rows[i].want);
    in_valid_i <= 1'b0;

    // longest trigger times under the widest timeout
    drain();
    apply_cfg('{settle_ticks: 8'd255, pulse_ticks: 8'd255, timeout_ticks: 16'hFFFF,
                near_threshold_cm: 10'd600});
    measure(2, 60);
    in_valid_i <= 1'b0;

    // random measurements under each idle pattern
    run_mode(0, 0, 48);
    run_mode(69, 0, 48);
    run_mode(0, 69, 48);
    run_mode(28, 28, 48);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb_ultrasonic_range_measurer: clean");
    end else begin
      $display("tb_ultrasonic_range_measurer: errors");
    end
    $finish;
  end

endmodule

// ===== ultrasonic_range_measurer.f =====
rtl/core/urm_pkg.sv
rtl/core/urm_cfg.sv
rtl/core/urm_core.sv
rtl/core/ultrasonic_range_measurer.sv
sim/tb_ultrasonic_range_measurer.sv
